// ===== sv/rlcs_pkg.sv =====
`timescale 1ns / 1ps

package rlcs_pkg;

    localparam int TICK_W = 16;
    localparam int CHAN_W = 8;
    localparam int WORD_W = 3 * CHAN_W;
    localparam int BIT_W  = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [BIT_W-1:0] LAST_BIT = 5'd23;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_LATCH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_GAP = 3'd4;

    localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 16'd100;
    localparam logic [TICK_W-1:0] RST_ONE_LOW   = 16'd70;
    localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 16'd35;
    localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 16'd120;
    localparam logic [TICK_W-1:0] RST_LATCH_GAP = 16'd12000;

    typedef struct packed {
        logic              done;
        logic [CHAN_W-1:0] quotient;
    } div_stat_t;

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        at_least_one = (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

// ===== sv/rgb_led_chain_serializer.sv =====
`timescale 1ns / 1ps

// Single-wire RGB LED chain serializer.
// Input channel (in_valid/in_ready): mode 0 is one tick of line time, mode 1
// a color request (red_in, green_in, blue_in). Every input beat gives exactly
// one output beat (out_valid/out_ready) carrying line_level, busy_res and
// frame_done. Ticks and requests that arrive while a frame is busy answer
// directly and may follow back to back while the receiver takes each beat;
// the output register lets a new beat in while the previous result drains.
// A color request taken while idle with a nonzero peak is scaled to
// channel*255/peak by one shared restoring divider, eight steps per channel,
// three channels in turn: in_ready stays low until the result beat is
// registered. A request whose channels are all zero skips the divider and
// is answered directly.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// indexes above four are dropped. New timing values apply at the next phase.
// Reset clears the frame to idle and the timing registers to their defaults.
// A stalled receiver holds the output beat and in_ready drops until it is
// taken; no beat is lost.
module rgb_led_chain_serializer
#(
    parameter int LED_COUNT = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [rlcs_pkg::CHAN_W-1:0]      red_in,
    input  logic [rlcs_pkg::CHAN_W-1:0]      green_in,
    input  logic [rlcs_pkg::CHAN_W-1:0]      blue_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             line_level,
    output logic                             busy_res,
    output logic                             frame_done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rlcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlcs_pkg::TICK_W-1:0]      cfg_data
);

    localparam int LED_W = $clog2(LED_COUNT + 1);
    localparam logic [LED_W-1:0] LED_LAST = LED_W'(LED_COUNT);

    localparam logic [1:0] SQ_IDLE = 2'd0;
    localparam logic [1:0] SQ_DIV  = 2'd1;
    localparam logic [1:0] SQ_EMIT = 2'd2;

    localparam int CW = rlcs_pkg::CHAN_W;
    localparam int TW = rlcs_pkg::TICK_W;
    localparam int BW = rlcs_pkg::BIT_W;

    logic [TW-1:0] one_high_reg;
    logic [TW-1:0] one_low_reg;
    logic [TW-1:0] zero_high_reg;
    logic [TW-1:0] zero_low_reg;
    logic [TW-1:0] latch_gap_reg;

    logic [1:0]    sq_reg;
    logic [1:0]    sq_next;
    logic [1:0]    ch_reg;
    logic [1:0]    ch_next;
    logic [CW-1:0] g_reg;
    logic [CW-1:0] g_next;
    logic [CW-1:0] b_reg;
    logic [CW-1:0] b_next;
    logic [CW-1:0] peak_reg;
    logic [CW-1:0] peak_next;
    logic [CW-1:0] sr_reg;
    logic [CW-1:0] sr_next;
    logic [CW-1:0] sg_reg;
    logic [CW-1:0] sg_next;
    logic [CW-1:0] sb_reg;
    logic [CW-1:0] sb_next;

    logic [1:0]                     phase_reg;
    logic [1:0]                     phase_next;
    logic [TW-1:0]                  tick_reg;
    logic [TW-1:0]                  tick_next;
    logic [BW-1:0]                  bit_reg;
    logic [BW-1:0]                  bit_next;
    logic [LED_W-1:0]               led_reg;
    logic [LED_W-1:0]               led_next;
    logic [rlcs_pkg::WORD_W-1:0]    pixel_reg;
    logic [rlcs_pkg::WORD_W-1:0]    pixel_next;

    logic out_valid_reg;
    logic out_valid_next;
    logic level_reg;
    logic level_next;
    logic busy_reg;
    logic busy_next;
    logic done_reg;
    logic done_next;

    logic                          slot_free;
    logic                          accept;
    logic [CW-1:0]                 peak_in;
    logic                          req_scale;
    logic                          req_plain;
    logic                          emit;
    logic [rlcs_pkg::WORD_W-1:0]   start_word;
    logic [TW-1:0]                 tick_dec;
    logic                          bit_wrap;
    logic [BW-1:0]                 bit_adv;
    logic [LED_W-1:0]              led_adv;
    logic                          cur_bit;
    logic                          adv_bit;
    logic                          div_start;
    logic [CW-1:0]                 div_chan;
    logic [2*CW-1:0]               div_num;
    logic [CW-1:0]                 div_den;
    rlcs_pkg::div_stat_t           div_stat;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (sq_reg == SQ_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        peak_in = red_in;
        if (green_in > peak_in)
        begin
            peak_in = green_in;
        end
        if (blue_in > peak_in)
        begin
            peak_in = blue_in;
        end
    end

    assign req_scale = accept && mode && (phase_reg == rlcs_pkg::PH_IDLE) && (peak_in != '0);
    assign req_plain = accept && mode && (phase_reg == rlcs_pkg::PH_IDLE) && (peak_in == '0);
    assign emit      = (sq_reg == SQ_EMIT) && slot_free;
    assign start_word = emit ? {sg_reg, sr_reg, sb_reg} : {green_in, red_in, blue_in};

    assign div_start = req_scale
                    || ((sq_reg == SQ_DIV) && div_stat.done && (ch_reg != 2'd2));
    assign div_chan  = (sq_reg == SQ_IDLE) ? red_in : ((ch_reg == 2'd0) ? g_reg : b_reg);
    assign div_den   = (sq_reg == SQ_IDLE) ? peak_in : peak_reg;
    assign div_num   = {div_chan, CW'(0)} - {CW'(0), div_chan};

    rlcs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat)
    );

    assign tick_dec = (tick_reg != '0) ? (tick_reg - TW'(1)) : '0;
    assign bit_wrap = (bit_reg == rlcs_pkg::LAST_BIT);
    assign bit_adv  = bit_wrap ? '0 : (bit_reg + BW'(1));
    assign led_adv  = bit_wrap ? (led_reg + LED_W'(1)) : led_reg;
    assign cur_bit  = pixel_reg[rlcs_pkg::LAST_BIT - bit_reg];
    assign adv_bit  = pixel_reg[rlcs_pkg::LAST_BIT - bit_adv];

    always_comb
    begin
        sq_next    = sq_reg;
        ch_next    = ch_reg;
        g_next     = g_reg;
        b_next     = b_reg;
        peak_next  = peak_reg;
        sr_next    = sr_reg;
        sg_next    = sg_reg;
        sb_next    = sb_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        led_next   = led_reg;
        pixel_next = pixel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        level_next = level_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;

        if (req_plain || emit)
        begin
            pixel_next = start_word;
            bit_next   = '0;
            led_next   = '0;
            phase_next = rlcs_pkg::PH_HIGH;
            tick_next  = rlcs_pkg::at_least_one(start_word[rlcs_pkg::WORD_W-1]
                                                ? one_high_reg : zero_high_reg);
            out_valid_next = 1'b1;
            level_next = 1'b1;
            busy_next  = 1'b1;
            done_next  = 1'b0;
            sq_next    = SQ_IDLE;
        end
        else if (req_scale)
        begin
            g_next    = green_in;
            b_next    = blue_in;
            peak_next = peak_in;
            ch_next   = 2'd0;
            sq_next   = SQ_DIV;
        end
        else if (accept)
        begin
            out_valid_next = 1'b1;
            level_next = (phase_reg == rlcs_pkg::PH_HIGH);
            busy_next  = (phase_reg != rlcs_pkg::PH_IDLE);
            done_next  = 1'b0;
            if (!mode && (phase_reg != rlcs_pkg::PH_IDLE))
            begin
                tick_next = tick_dec;
                if (tick_dec == '0)
                begin
                    case (phase_reg)
                        rlcs_pkg::PH_HIGH:
                        begin
                            phase_next = rlcs_pkg::PH_LOW;
                            tick_next  = rlcs_pkg::at_least_one(cur_bit ? one_low_reg
                                                                        : zero_low_reg);
                        end
                        rlcs_pkg::PH_LOW:
                        begin
                            bit_next = bit_adv;
                            led_next = led_adv;
                            if (led_adv >= LED_LAST)
                            begin
                                phase_next = rlcs_pkg::PH_LATCH;
                                tick_next  = rlcs_pkg::at_least_one(latch_gap_reg);
                            end
                            else
                            begin
                                phase_next = rlcs_pkg::PH_HIGH;
                                tick_next  = rlcs_pkg::at_least_one(adv_bit ? one_high_reg
                                                                            : zero_high_reg);
                            end
                        end
                        rlcs_pkg::PH_LATCH:
                        begin
                            done_next  = 1'b1;
                            phase_next = rlcs_pkg::PH_IDLE;
                            bit_next   = '0;
                            led_next   = '0;
                        end
                        default:
                        begin
                            phase_next = rlcs_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
        end

        if ((sq_reg == SQ_DIV) && div_stat.done)
        begin
            case (ch_reg)
                2'd0:
                begin
                    sr_next = div_stat.quotient;
                    ch_next = 2'd1;
                end
                2'd1:
                begin
                    sg_next = div_stat.quotient;
                    ch_next = 2'd2;
                end
                default:
                begin
                    sb_next = div_stat.quotient;
                    sq_next = SQ_EMIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= rlcs_pkg::RST_ONE_HIGH;
            one_low_reg   <= rlcs_pkg::RST_ONE_LOW;
            zero_high_reg <= rlcs_pkg::RST_ZERO_HIGH;
            zero_low_reg  <= rlcs_pkg::RST_ZERO_LOW;
            latch_gap_reg <= rlcs_pkg::RST_LATCH_GAP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rlcs_pkg::REG_ONE_HIGH:  one_high_reg  <= cfg_data;
                rlcs_pkg::REG_ONE_LOW:   one_low_reg   <= cfg_data;
                rlcs_pkg::REG_ZERO_HIGH: zero_high_reg <= cfg_data;
                rlcs_pkg::REG_ZERO_LOW:  zero_low_reg  <= cfg_data;
                rlcs_pkg::REG_LATCH_GAP: latch_gap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg        <= SQ_IDLE;
            ch_reg        <= 2'd0;
            phase_reg     <= rlcs_pkg::PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            led_reg       <= '0;
            pixel_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sq_reg        <= sq_next;
            ch_reg        <= ch_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bit_reg       <= bit_next;
            led_reg       <= led_next;
            pixel_reg     <= pixel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg     <= g_next;
        b_reg     <= b_next;
        peak_reg  <= peak_next;
        sr_reg    <= sr_next;
        sg_reg    <= sg_next;
        sb_reg    <= sb_next;
        level_reg <= level_next;
        busy_reg  <= busy_next;
        done_reg  <= done_next;
    end

    assign out_valid  = out_valid_reg;
    assign line_level = level_reg;
    assign busy_res   = busy_reg;
    assign frame_done = done_reg;

endmodule

// ===== sv/rlcs_div.sv =====
`timescale 1ns / 1ps

module rlcs_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [2*rlcs_pkg::CHAN_W-1:0] num,
    input  logic [rlcs_pkg::CHAN_W-1:0]   den,
    output rlcs_pkg::div_stat_t           stat
);

    logic [3:0]                   cnt_reg;
    logic [3:0]                   cnt_next;
    logic                         done_reg;
    logic                         done_next;
    logic [rlcs_pkg::CHAN_W-1:0]  rem_reg;
    logic [rlcs_pkg::CHAN_W-1:0]  rem_next;
    logic [rlcs_pkg::CHAN_W-1:0]  quo_reg;
    logic [rlcs_pkg::CHAN_W-1:0]  quo_next;
    logic [rlcs_pkg::CHAN_W-1:0]  den_reg;
    logic [rlcs_pkg::CHAN_W-1:0]  den_next;
    logic [rlcs_pkg::CHAN_W:0]    trial;
    logic [rlcs_pkg::CHAN_W:0]    diff;
    logic                         fits;

    assign trial = {rem_reg, quo_reg[rlcs_pkg::CHAN_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            rem_next = num[2*rlcs_pkg::CHAN_W-1:rlcs_pkg::CHAN_W];
            quo_next = num[rlcs_pkg::CHAN_W-1:0];
            den_next = den;
            cnt_next = 4'(rlcs_pkg::CHAN_W);
        end
        else if (cnt_reg != 4'd0)
        begin
            rem_next  = fits ? diff[rlcs_pkg::CHAN_W-1:0] : trial[rlcs_pkg::CHAN_W-1:0];
            quo_next  = {quo_reg[rlcs_pkg::CHAN_W-2:0], fits};
            cnt_next  = cnt_reg - 4'd1;
            done_next = (cnt_reg == 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 4'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

// ===== sv/rlcs_checker.sv =====
`timescale 1ns / 1ps

module rlcs_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic mode,
    input logic out_valid,
    input logic out_ready,
    input logic line_level,
    input logic busy_res,
    input logic frame_done
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> busy_res)
        else $error("frame_done without busy_res");

    a_done_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !line_level)
        else $error("frame_done with line high");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output beat stalled");

    a_tick_answer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !mode |=> out_valid)
        else $error("tick beat gave no output beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_level) && $stable(busy_res))
        else $error("stalled output beat changed");

endmodule

bind rgb_led_chain_serializer rlcs_checker u_rlcs_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_level (line_level),
    .busy_res   (busy_res),
    .frame_done (frame_done)
);

// ===== verif/tb_rgb_led_chain_serializer.sv =====
`timescale 1ns / 1ps

module tb_rgb_led_chain_serializer;

    localparam int CFG_IDX_W = rlcs_pkg::CFG_IDX_W;
    localparam int CHAN_W    = rlcs_pkg::CHAN_W;
    localparam int TICK_W    = rlcs_pkg::TICK_W;
    localparam int WORD_W    = rlcs_pkg::WORD_W;

    localparam int CHAIN_LEN      = 8;
    localparam int STALL_LIMIT    = 2000;
    localparam int SQUEEZE_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_BEATS    = 56;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_COLOR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic level;
        logic busy;
        logic done;
    } line_beat_t;

    typedef struct packed {
        logic              mode;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              typed;
        logic              want_level;
        logic              want_busy;
        logic              want_done;
        logic              drain;
    } line_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid;
    logic                 in_ready;
    logic                 mode;
    logic [CHAN_W-1:0]    red_in;
    logic [CHAN_W-1:0]    green_in;
    logic [CHAN_W-1:0]    blue_in;
    logic                 out_valid;
    logic                 out_ready;
    logic                 line_level;
    logic                 busy_res;
    logic                 frame_done;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;

    logic [1:0]        ln_phase;
    logic [TICK_W-1:0] ln_left;
    int                ln_bit;
    int                ln_led;
    logic [WORD_W-1:0] ln_word;
    logic [TICK_W-1:0] tick_reg [0:4];

    line_beat_t line_expect [$];
    int         mismatches = 0;
    int         stall_cycles = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    bit         squeeze_req = 1'b0;

    line_row_t line_rows [7] = '{
        {MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        {MODE_COLOR, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        {MODE_COLOR, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        {MODE_TICK,  8'h5a, 8'ha5, 8'h3c, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
        {MODE_TICK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        {MODE_TICK,  8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        {MODE_COLOR, 8'hc8, 8'h64, 8'h32, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}
    };

    rgb_led_chain_serializer #(
        .LED_COUNT (CHAIN_LEN)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_level (line_level),
        .busy_res   (busy_res),
        .frame_done (frame_done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TICK_W-1:0] tick_count(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    function automatic void load_bit_high();
        ln_phase = rlcs_pkg::PH_HIGH;
        ln_left  = tick_count(ln_word[WORD_W-1-ln_bit] ? tick_reg[rlcs_pkg::REG_ONE_HIGH]
                                                         : tick_reg[rlcs_pkg::REG_ZERO_HIGH]);
    endfunction

    function automatic line_beat_t step_line(input logic m,
                                             input logic [CHAN_W-1:0] r, g, b);
        line_beat_t o;
        int         rs;
        int         gs;
        int         bs;
        int         peak;
        o  = '0;
        rs = r;
        gs = g;
        bs = b;
        if (m == MODE_COLOR)
        begin
            if (ln_phase == rlcs_pkg::PH_IDLE)
            begin
                peak = rs;
                if (gs > peak) peak = gs;
                if (bs > peak) peak = bs;
                if (peak != 0)
                begin
                    rs = rs * 255 / peak;
                    gs = gs * 255 / peak;
                    bs = bs * 255 / peak;
                end
                ln_word = {gs[7:0], rs[7:0], bs[7:0]};
                ln_bit  = 0;
                ln_led  = 0;
                load_bit_high();
            end
            o.level = (ln_phase == rlcs_pkg::PH_HIGH);
            o.busy  = 1'b1;
        end
        else if (ln_phase != rlcs_pkg::PH_IDLE)
        begin
            o.level = (ln_phase == rlcs_pkg::PH_HIGH);
            o.busy  = 1'b1;
            if (ln_left != '0) ln_left = ln_left - TICK_W'(1);
            if (ln_left == '0)
            begin
                case (ln_phase)
                    rlcs_pkg::PH_HIGH:
                    begin
                        ln_phase = rlcs_pkg::PH_LOW;
                        ln_left  = tick_count(ln_word[WORD_W-1-ln_bit]
                                              ? tick_reg[rlcs_pkg::REG_ONE_LOW]
                                              : tick_reg[rlcs_pkg::REG_ZERO_LOW]);
                    end
                    rlcs_pkg::PH_LOW:
                    begin
                        ln_bit++;
                        if (ln_bit >= WORD_W)
                        begin
                            ln_bit = 0;
                            ln_led++;
                        end
                        if (ln_led >= CHAIN_LEN)
                        begin
                            ln_phase = rlcs_pkg::PH_LATCH;
                            ln_left  = tick_count(tick_reg[rlcs_pkg::REG_LATCH_GAP]);
                        end
                        else
                        begin
                            load_bit_high();
                        end
                    end
                    default:
                    begin
                        o.done   = 1'b1;
                        ln_phase = rlcs_pkg::PH_IDLE;
                        ln_bit   = 0;
                        ln_led   = 0;
                    end
                endcase
            end
        end
        return o;
    endfunction

    function automatic logic [CHAN_W-1:0] pick_chan();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(255));
        endcase
    endfunction

    task automatic offer_beat(input logic m, input logic [CHAN_W-1:0] r, g, b,
                              input line_beat_t want);
        while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
        line_expect.push_back(want);
        in_valid = 1'b1;
        mode     = m;
        red_in   = r;
        green_in = g;
        blue_in  = b;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic offer_predicted(input logic m, input logic [CHAN_W-1:0] r, g, b);
        offer_beat(m, r, g, b, step_line(m, r, g, b));
    endtask

    task automatic drain_frame();
        while (ln_phase != rlcs_pkg::PH_IDLE)
            offer_predicted(MODE_TICK, pick_chan(), pick_chan(), pick_chan());
    endtask

    task automatic write_tick_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TICK_W-1:0] val);
        while (line_expect.size() != 0) @(negedge clk);
        if (idx <= rlcs_pkg::REG_LATCH_GAP) tick_reg[idx] = val;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic retime(input logic [TICK_W-1:0] one_hi, one_lo, zero_hi, zero_lo, gap);
        write_tick_reg(rlcs_pkg::REG_ONE_HIGH, one_hi);
        write_tick_reg(rlcs_pkg::REG_ONE_LOW, one_lo);
        write_tick_reg(rlcs_pkg::REG_ZERO_HIGH, zero_hi);
        write_tick_reg(rlcs_pkg::REG_ZERO_LOW, zero_lo);
        write_tick_reg(rlcs_pkg::REG_LATCH_GAP, gap);
    endtask

    task automatic walk_rows(input int first, input int last);
        line_row_t  row;
        line_beat_t want;
        for (int i = first; i <= last; i++)
        begin
            row  = line_rows[i];
            want = step_line(row.mode, row.red, row.green, row.blue);
            if (row.typed)
                want = '{row.want_level, row.want_busy, row.want_done};
            offer_beat(row.mode, row.red, row.green, row.blue, want);
            if (row.drain) drain_frame();
        end
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input bit squeeze);
        int   taken;
        bit   squeezed;
        logic m;
        taken    = 0;
        squeezed = 1'b0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        retime(TICK_W'($urandom_range(2)), TICK_W'($urandom_range(2)),
               TICK_W'($urandom_range(2)), TICK_W'($urandom_range(2)),
               TICK_W'($urandom_range(8)));
        while (taken < PHASE_BEATS)
        begin
            if (squeeze && !squeezed && taken >= PHASE_BEATS / 2)
            begin
                squeeze_req = 1'b1;
                squeezed    = 1'b1;
            end
            if (ln_phase == rlcs_pkg::PH_IDLE)
                m = ($urandom_range(3) != 0) ? MODE_COLOR : MODE_TICK;
            else
                m = ($urandom_range(24) == 0) ? MODE_COLOR : MODE_TICK;
            if (!(m == MODE_COLOR && ln_phase != rlcs_pkg::PH_IDLE)) taken++;
            offer_predicted(m, pick_chan(), pick_chan(), pick_chan());
        end
    endtask

    // drop ready at random; hold it low for a long stretch on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                out_ready   = 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        line_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (line_expect.size() == 0)
            begin
                $error("unexpected beat: line_level %0b busy_res %0b frame_done %0b",
                       line_level, busy_res, frame_done);
                mismatches++;
            end
            else
            begin
                want = line_expect.pop_front();
                if (line_level !== want.level)
                begin
                    $error("line_level: expected %0b, actual %0b", want.level, line_level);
                    mismatches++;
                end
                if (busy_res !== want.busy)
                begin
                    $error("busy_res: expected %0b, actual %0b", want.busy, busy_res);
                    mismatches++;
                end
                if (frame_done !== want.done)
                begin
                    $error("frame_done: expected %0b, actual %0b", want.done, frame_done);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        in_valid  = 1'b0;
        mode      = MODE_TICK;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        cfg_valid = 1'b0;
        cfg_index = rlcs_pkg::REG_ONE_HIGH;
        cfg_data  = '0;

        ln_phase = rlcs_pkg::PH_IDLE;
        ln_left  = '0;
        ln_bit   = 0;
        ln_led   = 0;
        ln_word  = '0;
        tick_reg[rlcs_pkg::REG_ONE_HIGH]  = rlcs_pkg::RST_ONE_HIGH;
        tick_reg[rlcs_pkg::REG_ONE_LOW]   = rlcs_pkg::RST_ONE_LOW;
        tick_reg[rlcs_pkg::REG_ZERO_HIGH] = rlcs_pkg::RST_ZERO_HIGH;
        tick_reg[rlcs_pkg::REG_ZERO_LOW]  = rlcs_pkg::RST_ZERO_LOW;
        tick_reg[rlcs_pkg::REG_LATCH_GAP] = rlcs_pkg::RST_LATCH_GAP;

        tx_idle_pct = 28;
        rx_idle_pct = 50;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // retime mid-frame so the reset timing drains quickly
        walk_rows(0, 4);
        retime(16'd2, 16'd1, 16'd1, 16'd1, 16'd2);
        write_tick_reg(REG_SPARE_LO, 16'hffff);
        write_tick_reg(REG_SPARE_HI, 16'hffff);
        drain_frame();
        walk_rows(5, 6);

        random_phase(28, 50, 1'b1);
        random_phase(50, 28, 1'b0);
        random_phase(0, 0, 1'b0);

        while (line_expect.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
